>>> rtl/mmi3_simd_execute_core_macros.svh
// Assertion helpers for the MMI3 execute core.
`ifndef MMI3_SIMD_EXECUTE_CORE_MACROS_SVH
`define MMI3_SIMD_EXECUTE_CORE_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define MMI3_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition implies a consequence on the next edge.
`define MMI3_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/mmi3_pkg.sv
package mmi3_pkg;

	localparam logic [4:0] OP_PMADDUW = 5'd0;
	localparam logic [4:0] OP_PMTHI   = 5'd8;
	localparam logic [4:0] OP_PMTLO   = 5'd9;
	localparam logic [4:0] OP_PINTEH  = 5'd10;
	localparam logic [4:0] OP_PMULTUW = 5'd12;
	localparam logic [4:0] OP_PDIVUW  = 5'd13;
	localparam logic [4:0] OP_PCPYUD  = 5'd14;
	localparam logic [4:0] OP_POR     = 5'd18;
	localparam logic [4:0] OP_PNOR    = 5'd19;
	localparam logic [4:0] OP_PEXCH   = 5'd26;
	localparam logic [4:0] OP_PCPYH   = 5'd27;
	localparam logic [4:0] OP_PEXCW   = 5'd30;

	// Decoded operation class.
	localparam logic [2:0] CL_PERM  = 3'd0;
	localparam logic [2:0] CL_MADD  = 3'd1;
	localparam logic [2:0] CL_MULT  = 3'd2;
	localparam logic [2:0] CL_DIV   = 3'd3;
	localparam logic [2:0] CL_MTHI  = 3'd4;
	localparam logic [2:0] CL_MTLO  = 3'd5;
	localparam logic [2:0] CL_BAD   = 3'd6;

	localparam int DivSteps = 32;

	typedef struct packed {
		logic [4:0]  req_type;
		logic [63:0] rs_low;
		logic [63:0] rs_high;
		logic [63:0] rt_low;
		logic [63:0] rt_high;
	} req_t;

	typedef struct packed {
		logic [63:0] rd_low;
		logic [63:0] rd_high;
		logic        rd_write;
		logic        status;
	} rsp_t;

	// Classified word held in the queue.
	typedef struct packed {
		logic [2:0]  cls;
		logic [63:0] rs_low;
		logic [63:0] rs_high;
		logic [63:0] rt_low;
		logic [63:0] rt_high;
		logic [63:0] perm_low;
		logic [63:0] perm_high;
	} op_t;

	function automatic logic [63:0] sext32(input logic [31:0] v);
		sext32 = {{32{v[31]}}, v};
	endfunction

	function automatic logic [63:0] inteh64(input logic [63:0] s, input logic [63:0] t);
		inteh64 = {s[47:32], t[47:32], s[15:0], t[15:0]};
	endfunction

	function automatic logic [63:0] exch64(input logic [63:0] t);
		exch64 = {t[63:48], t[31:16], t[47:32], t[15:0]};
	endfunction

	function automatic logic [63:0] cpyh64(input logic [63:0] t);
		cpyh64 = {4{t[15:0]}};
	endfunction

endpackage

>>> rtl/mmi3_front.sv
module mmi3_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  mmi3_pkg::req_t  req,
	output logic            q_valid,
	input  logic            q_ready,
	output mmi3_pkg::op_t   q_word
);

	// Two-entry queue.
	mmi3_pkg::op_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	mmi3_pkg::op_t op;
	logic          push, pop;

	always_comb begin
		op.rs_low    = req.rs_low;
		op.rs_high   = req.rs_high;
		op.rt_low    = req.rt_low;
		op.rt_high   = req.rt_high;
		op.perm_low  = '0;
		op.perm_high = '0;
		op.cls       = mmi3_pkg::CL_PERM;
		unique case (req.req_type)
			mmi3_pkg::OP_PMADDUW: op.cls = mmi3_pkg::CL_MADD;
			mmi3_pkg::OP_PMULTUW: op.cls = mmi3_pkg::CL_MULT;
			mmi3_pkg::OP_PDIVUW:  op.cls = mmi3_pkg::CL_DIV;
			mmi3_pkg::OP_PMTHI:   op.cls = mmi3_pkg::CL_MTHI;
			mmi3_pkg::OP_PMTLO:   op.cls = mmi3_pkg::CL_MTLO;
			mmi3_pkg::OP_PINTEH: begin
				op.perm_low  = mmi3_pkg::inteh64(req.rs_low, req.rt_low);
				op.perm_high = mmi3_pkg::inteh64(req.rs_high, req.rt_high);
			end
			mmi3_pkg::OP_PCPYUD: begin
				op.perm_low  = req.rs_high;
				op.perm_high = req.rt_high;
			end
			mmi3_pkg::OP_POR: begin
				op.perm_low  = req.rs_low | req.rt_low;
				op.perm_high = req.rs_high | req.rt_high;
			end
			mmi3_pkg::OP_PNOR: begin
				op.perm_low  = ~(req.rs_low | req.rt_low);
				op.perm_high = ~(req.rs_high | req.rt_high);
			end
			mmi3_pkg::OP_PEXCH: begin
				op.perm_low  = mmi3_pkg::exch64(req.rt_low);
				op.perm_high = mmi3_pkg::exch64(req.rt_high);
			end
			mmi3_pkg::OP_PCPYH: begin
				op.perm_low  = mmi3_pkg::cpyh64(req.rt_low);
				op.perm_high = mmi3_pkg::cpyh64(req.rt_high);
			end
			mmi3_pkg::OP_PEXCW: begin
				op.perm_low  = {req.rt_high[31:0], req.rt_low[31:0]};
				op.perm_high = {req.rt_high[63:32], req.rt_low[63:32]};
			end
			default: op.cls = mmi3_pkg::CL_BAD;
		endcase
	end

	assign req_ready = (cnt_q != 2'd2);
	assign q_valid   = (cnt_q != 2'd0);
	assign push      = req_valid && req_ready;
	assign pop       = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= op;
		end
	end
	assign q_word = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> rtl/mmi3_back.sv
module mmi3_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  mmi3_pkg::op_t   q_word,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output mmi3_pkg::rsp_t  rsp,
	output logic            busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  st_q;
	logic [2:0]  cls_q;
	logic [63:0] hi_q [2];
	logic [63:0] lo_q [2];
	logic [31:0] a_q [2];
	logic [31:0] b_q [2];
	logic [63:0] prod_q [2];
	logic [31:0] quo_q [2];
	logic [31:0] rem_q [2];
	logic [5:0]  cnt_q;
	mmi3_pkg::rsp_t out_q;
	logic        out_v_q;
	logic [32:0] trial [2];
	logic [63:0] sum [2];

	assign q_ready   = (st_q == ST_IDLE) && !out_v_q;
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;
	assign busy      = (st_q != ST_IDLE);

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial[i] = {rem_q[i], quo_q[i][31]} - {1'b0, b_q[i]};
			sum[i]   = prod_q[i] + ((cls_q == mmi3_pkg::CL_MADD) ?
				{hi_q[i][31:0], lo_q[i][31:0]} : 64'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid && !out_v_q) begin
			a_q[0] <= q_word.rs_low[31:0];
			a_q[1] <= q_word.rs_high[31:0];
			b_q[0] <= q_word.rt_low[31:0];
			b_q[1] <= q_word.rt_high[31:0];
			quo_q[0] <= q_word.rs_low[31:0];
			quo_q[1] <= q_word.rs_high[31:0];
			rem_q[0] <= '0;
			rem_q[1] <= '0;
		end else if (st_q == ST_MUL) begin
			prod_q[0] <= a_q[0] * b_q[0];
			prod_q[1] <= a_q[1] * b_q[1];
		end else if (st_q == ST_DIV) begin
			// Restoring divide, one quotient bit per cycle and lane.
			for (int i = 0; i < 2; i++) begin
				if (!trial[i][32]) begin
					rem_q[i] <= trial[i][31:0];
					quo_q[i] <= {quo_q[i][30:0], 1'b1};
				end else begin
					rem_q[i] <= {rem_q[i][30:0], quo_q[i][31]};
					quo_q[i] <= {quo_q[i][30:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cls_q   <= mmi3_pkg::CL_PERM;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
			out_q   <= '0;
			for (int i = 0; i < 2; i++) begin
				hi_q[i] <= '0;
				lo_q[i] <= '0;
			end
		end else begin
			if (out_v_q && rsp_ready) out_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid && !out_v_q) begin
						cls_q <= q_word.cls;
						unique case (q_word.cls)
							mmi3_pkg::CL_MADD, mmi3_pkg::CL_MULT: begin
								out_q <= '0;
								st_q  <= ST_MUL;
							end
							mmi3_pkg::CL_DIV: begin
								out_q <= '0;
								st_q  <= ST_DIV;
								cnt_q <= '0;
							end
							mmi3_pkg::CL_MTHI: begin
								hi_q[0] <= q_word.rs_low;
								hi_q[1] <= q_word.rs_high;
								out_q   <= '0;
								out_v_q <= 1'b1;
							end
							mmi3_pkg::CL_MTLO: begin
								lo_q[0] <= q_word.rs_low;
								lo_q[1] <= q_word.rs_high;
								out_q   <= '0;
								out_v_q <= 1'b1;
							end
							mmi3_pkg::CL_BAD: begin
								out_q   <= {64'd0, 64'd0, 1'b0, 1'b1};
								out_v_q <= 1'b1;
							end
							default: begin
								out_q   <= {q_word.perm_low, q_word.perm_high, 1'b1, 1'b0};
								out_v_q <= 1'b1;
							end
						endcase
					end
				end
				ST_MUL: st_q <= ST_OUT;
				ST_OUT: begin
					// Fold the product into HI/LO and drive rd.
					for (int i = 0; i < 2; i++) begin
						hi_q[i] <= mmi3_pkg::sext32(sum[i][63:32]);
						lo_q[i] <= mmi3_pkg::sext32(sum[i][31:0]);
					end
					out_q   <= {sum[0], sum[1], 1'b1, 1'b0};
					out_v_q <= 1'b1;
					st_q    <= ST_IDLE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(mmi3_pkg::DivSteps)) begin
						for (int i = 0; i < 2; i++) begin
							if (b_q[i] != '0) begin
								hi_q[i] <= mmi3_pkg::sext32(rem_q[i]);
								lo_q[i] <= mmi3_pkg::sext32(quo_q[i]);
							end
						end
						out_v_q <= 1'b1;
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/mmi3_simd_execute_core.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | mmi3_pkg::req_t
// rsp     | out       | rsp_valid / rsp_ready | mmi3_pkg::rsp_t
//
// Permute, logic, move and invalid words go from IDLE straight to the response;
// multiply and multiply-add pass through MUL and OUT; PDIVUW stays in DIV, the
// restoring divider retiring one quotient bit per cycle in each lane.
// A two-word queue decouples the decoder from the back end.
// Reset clears HI, LO, the queue and all valid flags.
// A stalled response holds the back end; the queue keeps taking words until full.
`include "mmi3_simd_execute_core_macros.svh"

module mmi3_simd_execute_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  mmi3_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output mmi3_pkg::rsp_t  rsp
);

	logic          q_valid, q_ready, busy;
	mmi3_pkg::op_t q_word;

	// Decode and queue.
	mmi3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_word    (q_word)
	);

	// Execute and hold HI/LO.
	mmi3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_word    (q_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.busy      (busy)
	);

	`MMI3_ASSERT_IMPL(a_no_take_busy, clk, arst_n, busy, !q_ready)
	`MMI3_ASSERT_IMPL(a_bad_no_write, clk, arst_n, rsp_valid && rsp.status, !rsp.rd_write)
	`MMI3_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

endmodule
